// File: rtl/core/tmpg_pkg.sv
// Types, codes and constants shared by the trapezoidal profile generator.
`default_nettype none

package tmpg_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int REG_W     = 31;
    localparam int TIME_W    = 32 + FRAC_BITS;
    localparam int DIVD_W    = 32 + FRAC_BITS;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 66;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 1'b1;
    localparam logic [REG_W-1:0] MAX_VEL_RESET = 31'd4587520;
    localparam logic [REG_W-1:0] ACCEL_RESET   = 31'd655360;

    // Item command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic              command;
        logic signed [31:0] target_position;
        logic signed [31:0] encoder_position;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] velocity_command;
        logic signed [31:0] position_setpoint;
        logic [1:0]         phase;
        logic               done_res;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    // Which part of the profile the current time falls in
    typedef enum logic [1:0] {
        CLS_FIN,
        CLS_ACC,
        CLS_CRU,
        CLS_DEC
    } eval_cls_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_MAG,
        OP_TICK,
        OP_MUL_VV,
        OP_MUL_MA,
        OP_CMP,
        OP_DIV_VA,
        OP_DIV_MV,
        OP_TRAP_END,
        OP_DIV_MA,
        OP_SQRT,
        OP_TRI_TA,
        OP_MUL_A_TA,
        OP_TRI_PK,
        OP_EVAL,
        OP_MUL_AE,
        OP_V_MIN,
        OP_MUL_VE,
        OP_ACC_HALF,
        OP_V_MIN16,
        OP_MUL_VTA,
        OP_CR_S1,
        OP_CR_ADD,
        OP_CR_SUB,
        OP_DE_ACE,
        OP_DE_V,
        OP_DE_VR,
        OP_MUL_WR,
        OP_DE_S,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_VV,
        ST_MUL_MA,
        ST_CMP,
        ST_BRANCH,
        ST_WAIT_VA,
        ST_WAIT_MV,
        ST_WAIT_MA,
        ST_WAIT_SQ,
        ST_TRI_MUL,
        ST_TRI_PK,
        ST_EVAL,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_C6,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_D5,
        ST_D6,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic      is_start;
        logic      trap;
        logic      div_done;
        logic      sqrt_done;
        eval_cls_t cls;
        logic      out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/tmpg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tmpg_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tmpg_pkg::DIVD_W-1:0]  dividend,
    input  wire logic [tmpg_pkg::REG_W-1:0]   divisor,
    output logic                              busy,
    output logic                              done,
    output logic [tmpg_pkg::DIVD_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(tmpg_pkg::DIVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tmpg_pkg::DIVD_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [tmpg_pkg::REG_W-1:0]   rem_reg;
    logic [tmpg_pkg::REG_W-1:0]   dsr_reg;
    logic [tmpg_pkg::DIVD_W-1:0]  quo_reg;

    logic [tmpg_pkg::REG_W:0]     trial;
    logic                         ge;
    logic [tmpg_pkg::REG_W-1:0]   rem_next;

    // One shift-subtract step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[tmpg_pkg::DIVD_W-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? tmpg_pkg::REG_W'(trial - {1'b0, dsr_reg})
                      : trial[tmpg_pkg::REG_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[tmpg_pkg::DIVD_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/tmpg_sqrt.sv
// Integer square root, one root bit per cycle.
`default_nettype none

module tmpg_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tmpg_pkg::RAD_W-1:0]  radicand,
    output logic                             done,
    output logic [tmpg_pkg::ROOT_W-1:0]      root
);

    localparam int CNT_W = $clog2(tmpg_pkg::ROOT_W);
    localparam int REM_W = tmpg_pkg::ROOT_W + 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tmpg_pkg::ROOT_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [tmpg_pkg::ROOT_W-1:0]  root_reg;
    logic [tmpg_pkg::RAD_W-1:0]   rad_reg;

    logic [REM_W-1:0]             rem_sh;
    logic [REM_W-1:0]             trial;
    logic                         ge;

    // Bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[tmpg_pkg::RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= radicand;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[tmpg_pkg::ROOT_W-2:0], ge};
            rad_reg  <= {rad_reg[tmpg_pkg::RAD_W-3:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/tmpg_datapath.sv
// Profile datapath: move state, shared multiplier, divider, square root, output register.
`default_nettype none

module tmpg_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tmpg_pkg::dp_op_t                op,
    output tmpg_pkg::dp_status_t                 status,
    input  wire tmpg_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output tmpg_pkg::out_item_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [tmpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmpg_pkg::REG_W-1:0]      cfg_data
);

    localparam int F     = tmpg_pkg::FRAC_BITS;
    localparam int CEIL_W = tmpg_pkg::PROD_W + 1 - F;

    // Configuration and move state
    logic [tmpg_pkg::REG_W-1:0]  max_vel_reg;
    logic [tmpg_pkg::REG_W-1:0]  accel_reg;
    tmpg_pkg::in_item_t          item_reg;
    logic [31:0]                 start_pos_reg;
    logic                        neg_reg;
    logic [31:0]                 mag_reg;
    logic [31:0]                 ta_reg;
    logic [31:0]                 total_reg;
    logic [31:0]                 peak_reg;
    logic [31:0]                 elapsed_reg;
    logic                        active_reg;
    logic                        out_valid_reg;
    tmpg_pkg::out_item_t         out_data_reg;

    // Scratch registers
    logic                        trap_reg;
    logic [tmpg_pkg::PROD_W-1:0] prod_reg;
    logic [tmpg_pkg::ACC_W-1:0]  acc_reg;
    logic [31:0]                 v_reg;
    logic [31:0]                 w_reg;
    logic [31:0]                 r_reg;
    tmpg_pkg::phase_t            phase_reg;
    logic                        done_reg;

    logic [tmpg_pkg::REG_W-1:0]  vm;
    logic [tmpg_pkg::REG_W-1:0]  acc_rate;
    logic [tmpg_pkg::TIME_W-1:0] t_val;
    logic [31:0]                 ce_val;
    tmpg_pkg::eval_cls_t         cls;
    logic [31:0]                 mul_x;
    logic [31:0]                 mul_y;
    logic [tmpg_pkg::PROD_W-1:0] prod_next;
    logic [tmpg_pkg::PROD_W:0]   ceil_sum;
    logic [CEIL_W-1:0]           ceil_prod;
    logic [tmpg_pkg::ACC_W-1:0]  dv;
    logic [tmpg_pkg::PROD_W-1:0] sub;
    logic [32:0]                 diff;
    logic [32:0]                 dmag;
    logic [31:0]                 q_sat;
    logic [32:0]                 tot_sum;
    logic [31:0]                 s32;
    logic [33:0]                 pos;
    logic [31:0]                 pos_sat;
    logic [31:0]                 vel;

    logic                        div_start;
    logic [tmpg_pkg::DIVD_W-1:0] div_dividend;
    logic [tmpg_pkg::REG_W-1:0]  div_divisor;
    logic                        div_busy;
    logic                        div_done;
    logic [tmpg_pkg::DIVD_W-1:0] div_q;
    logic                        sqrt_start;
    logic [tmpg_pkg::RAD_W-1:0]  sqrt_rad;
    logic                        sqrt_done;
    logic [tmpg_pkg::ROOT_W-1:0] sqrt_root;

    // Clamp a product to the peak velocity
    function automatic logic [31:0] clamp_pk(input logic [tmpg_pkg::PROD_W-1:0] x,
                                             input logic [31:0] pk);
        clamp_pk = (x > {32'd0, pk}) ? pk : x[31:0];
    endfunction

    // A register value of zero acts as one
    assign vm       = (max_vel_reg == '0) ? tmpg_pkg::REG_W'(1) : max_vel_reg;
    assign acc_rate = (accel_reg == '0) ? tmpg_pkg::REG_W'(1) : accel_reg;

    // Profile time and segment
    always_comb
    begin
        t_val  = {elapsed_reg, {F{1'b0}}};
        ce_val = (total_reg >= ta_reg) ? total_reg - ta_reg : 32'd0;
        priority if (!active_reg || t_val >= tmpg_pkg::TIME_W'(total_reg))
            cls = tmpg_pkg::CLS_FIN;
        else if (t_val <= tmpg_pkg::TIME_W'(ta_reg))
            cls = tmpg_pkg::CLS_ACC;
        else if (t_val <= tmpg_pkg::TIME_W'(ce_val))
            cls = tmpg_pkg::CLS_CRU;
        else
            cls = tmpg_pkg::CLS_DEC;
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (op)
            tmpg_pkg::OP_MUL_VV:   begin mul_x = 32'(vm);       mul_y = 32'(vm);       end
            tmpg_pkg::OP_MUL_MA:   begin mul_x = mag_reg;       mul_y = 32'(acc_rate); end
            tmpg_pkg::OP_MUL_A_TA: begin mul_x = 32'(acc_rate); mul_y = ta_reg;        end
            tmpg_pkg::OP_MUL_AE:   begin mul_x = 32'(acc_rate); mul_y = elapsed_reg;   end
            tmpg_pkg::OP_MUL_VE:   begin mul_x = v_reg;         mul_y = elapsed_reg;   end
            tmpg_pkg::OP_MUL_VTA:  begin mul_x = v_reg;         mul_y = ta_reg;        end
            tmpg_pkg::OP_CR_S1:    begin mul_x = peak_reg;      mul_y = elapsed_reg;   end
            tmpg_pkg::OP_CR_ADD:   begin mul_x = peak_reg;      mul_y = ta_reg;        end
            tmpg_pkg::OP_DE_ACE:   begin mul_x = 32'(acc_rate); mul_y = ce_val;        end
            tmpg_pkg::OP_DE_V:     begin mul_x = 32'(acc_rate); mul_y = r_reg;         end
            tmpg_pkg::OP_MUL_WR:   begin mul_x = w_reg;         mul_y = r_reg;         end
            default:               begin mul_x = 32'd0;         mul_y = 32'd0;         end
        endcase
        prod_next = tmpg_pkg::PROD_W'(mul_x) * tmpg_pkg::PROD_W'(mul_y);
    end

    // Derived arithmetic
    always_comb
    begin
        // ceil(prod / 2^F), used for the shifted time offsets
        ceil_sum  = {1'b0, prod_reg} + {{(tmpg_pkg::PROD_W + 1 - F){1'b0}}, {F{1'b1}}};
        ceil_prod = ceil_sum[tmpg_pkg::PROD_W:F];
        dv        = acc_reg - tmpg_pkg::ACC_W'(ceil_prod);
        sub       = prod_reg >> (F + 1);
        diff      = {item_reg.target_position[31], item_reg.target_position}
                  - {item_reg.encoder_position[31], item_reg.encoder_position};
        dmag      = diff[32] ? 33'd0 - diff : diff;
        q_sat     = (|div_q[tmpg_pkg::DIVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
        tot_sum   = {1'b0, ta_reg} + {1'b0, q_sat};
        // Setpoint: start +/- distance, saturated
        s32       = (|acc_reg[tmpg_pkg::ACC_W-1:32]) ? 32'hFFFF_FFFF : acc_reg[31:0];
        pos       = neg_reg ? {{2{start_pos_reg[31]}}, start_pos_reg} - {2'b00, s32}
                            : {{2{start_pos_reg[31]}}, start_pos_reg} + {2'b00, s32};
        priority if (!pos[33] && pos[32:31] != 2'b00)
            pos_sat = 32'h7FFF_FFFF;
        else if (pos[33] && pos[32:31] != 2'b11)
            pos_sat = 32'h8000_0000;
        else
            pos_sat = pos[31:0];
        vel       = neg_reg ? 32'd0 - v_reg : v_reg;
    end

    // Divider and root commands
    always_comb
    begin
        div_start    = (op == tmpg_pkg::OP_DIV_VA) || (op == tmpg_pkg::OP_DIV_MV)
                    || (op == tmpg_pkg::OP_DIV_MA);
        div_dividend = (op == tmpg_pkg::OP_DIV_VA)
                     ? tmpg_pkg::DIVD_W'({vm, {F{1'b0}}})
                     : tmpg_pkg::DIVD_W'({mag_reg, {F{1'b0}}});
        div_divisor  = (op == tmpg_pkg::OP_DIV_MV) ? vm : acc_rate;
        sqrt_start   = (op == tmpg_pkg::OP_SQRT);
        sqrt_rad     = tmpg_pkg::RAD_W'({div_q, {F{1'b0}}});
    end

    tmpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    tmpg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg <= tmpg_pkg::MAX_VEL_RESET;
            accel_reg   <= tmpg_pkg::ACCEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tmpg_pkg::CFG_MAX_VEL: max_vel_reg <= cfg_data;
                tmpg_pkg::CFG_ACCEL:   accel_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ta_reg        <= '0;
            total_reg     <= '0;
            peak_reg      <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            unique case (op)
                tmpg_pkg::OP_START_MAG:
                begin
                    start_pos_reg <= item_reg.encoder_position;
                    neg_reg       <= diff[32];
                    mag_reg       <= dmag[31:0];
                    elapsed_reg   <= '0;
                    active_reg    <= 1'b1;
                end
                tmpg_pkg::OP_TICK:
                begin
                    if (active_reg && elapsed_reg != 32'hFFFF_FFFF)
                        elapsed_reg <= elapsed_reg + 32'd1;
                end
                tmpg_pkg::OP_DIV_MV:
                    ta_reg <= q_sat;
                tmpg_pkg::OP_TRAP_END:
                begin
                    total_reg <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
                    peak_reg  <= 32'(vm);
                end
                tmpg_pkg::OP_TRI_TA:
                begin
                    ta_reg    <= sqrt_root;
                    total_reg <= sqrt_root[31] ? 32'hFFFF_FFFF : {sqrt_root[30:0], 1'b0};
                end
                tmpg_pkg::OP_TRI_PK:
                    peak_reg <= (prod_reg[tmpg_pkg::PROD_W-1:F] > 48'h7FFF_FFFF)
                              ? 32'h7FFF_FFFF : prod_reg[F+31:F];
                tmpg_pkg::OP_EVAL:
                begin
                    if (cls == tmpg_pkg::CLS_FIN)
                        active_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Scratch datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (op)
            tmpg_pkg::OP_LOAD:     item_reg <= in_data;
            tmpg_pkg::OP_MUL_MA:   acc_reg  <= tmpg_pkg::ACC_W'(prod_reg);
            tmpg_pkg::OP_CMP:      trap_reg <= acc_reg[tmpg_pkg::PROD_W-1:0] < prod_reg;
            tmpg_pkg::OP_EVAL:
            begin
                r_reg <= total_reg - t_val[31:0];
                unique case (cls)
                    tmpg_pkg::CLS_FIN:
                    begin
                        phase_reg <= tmpg_pkg::PH_IDLE;
                        done_reg  <= active_reg;
                        acc_reg   <= tmpg_pkg::ACC_W'(mag_reg);
                        v_reg     <= 32'd0;
                    end
                    tmpg_pkg::CLS_ACC: begin phase_reg <= tmpg_pkg::PH_ACCEL;  done_reg <= 1'b0; end
                    tmpg_pkg::CLS_CRU: begin phase_reg <= tmpg_pkg::PH_CRUISE; done_reg <= 1'b0; end
                    tmpg_pkg::CLS_DEC: begin phase_reg <= tmpg_pkg::PH_DECEL;  done_reg <= 1'b0; end
                    default: ;
                endcase
            end
            tmpg_pkg::OP_V_MIN:    v_reg   <= clamp_pk(prod_reg, peak_reg);
            tmpg_pkg::OP_ACC_HALF: acc_reg <= tmpg_pkg::ACC_W'(prod_reg >> 1);
            tmpg_pkg::OP_V_MIN16:  v_reg   <= clamp_pk(prod_reg >> F, peak_reg);
            tmpg_pkg::OP_CR_S1:    acc_reg <= tmpg_pkg::ACC_W'(prod_reg >> (F + 1));
            tmpg_pkg::OP_CR_ADD:   acc_reg <= acc_reg + tmpg_pkg::ACC_W'(prod_reg);
            tmpg_pkg::OP_CR_SUB:
            begin
                acc_reg <= dv;
                v_reg   <= peak_reg;
            end
            tmpg_pkg::OP_DE_ACE:   acc_reg <= tmpg_pkg::ACC_W'(prod_reg);
            tmpg_pkg::OP_DE_V:
                v_reg <= (dv >= tmpg_pkg::ACC_W'(peak_reg)) ? 32'd0 : peak_reg - dv[31:0];
            tmpg_pkg::OP_DE_VR:    w_reg <= clamp_pk(prod_reg >> F, peak_reg);
            tmpg_pkg::OP_DE_S:
                acc_reg <= (sub >= tmpg_pkg::PROD_W'(mag_reg))
                         ? '0 : tmpg_pkg::ACC_W'(tmpg_pkg::PROD_W'(mag_reg) - sub);
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (op == tmpg_pkg::OP_OUT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op == tmpg_pkg::OP_OUT)
        begin
            out_data_reg.velocity_command  <= vel;
            out_data_reg.position_setpoint <= pos_sat;
            out_data_reg.phase             <= phase_reg;
            out_data_reg.done_res          <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.is_start  = (item_reg.command == tmpg_pkg::CMD_START);
        status.trap      = trap_reg;
        status.div_done  = div_done;
        status.sqrt_done = sqrt_done;
        status.cls       = cls;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // Checks
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == tmpg_pkg::OP_OUT) |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transfer");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == tmpg_pkg::OP_EVAL && cls == tmpg_pkg::CLS_FIN) |=> !active_reg)
        else $error("move still active after finish");

    a_dec_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (op == tmpg_pkg::OP_EVAL && cls == tmpg_pkg::CLS_DEC) |=> (r_reg != 32'd0))
        else $error("decelerate with no remaining time");

endmodule

`default_nettype wire

// File: rtl/core/tmpg_ctrl.sv
// Controller that sequences start and tick computations through the datapath.
`default_nettype none

module tmpg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tmpg_pkg::dp_status_t status,
    output tmpg_pkg::dp_op_t          op
);

    tmpg_pkg::ctrl_state_t state_reg;
    tmpg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tmpg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != tmpg_pkg::ST_IDLE);

    // Next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = tmpg_pkg::OP_NONE;
        unique case (state_reg)
            tmpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = tmpg_pkg::OP_LOAD;
                    state_next = tmpg_pkg::ST_DISPATCH;
                end
            end
            tmpg_pkg::ST_DISPATCH:
            begin
                if (status.is_start)
                begin
                    op         = tmpg_pkg::OP_START_MAG;
                    state_next = tmpg_pkg::ST_MUL_VV;
                end
                else
                begin
                    op         = tmpg_pkg::OP_TICK;
                    state_next = tmpg_pkg::ST_EVAL;
                end
            end
            // Start: pick trapezoid or triangle
            tmpg_pkg::ST_MUL_VV: begin op = tmpg_pkg::OP_MUL_VV; state_next = tmpg_pkg::ST_MUL_MA; end
            tmpg_pkg::ST_MUL_MA: begin op = tmpg_pkg::OP_MUL_MA; state_next = tmpg_pkg::ST_CMP; end
            tmpg_pkg::ST_CMP:    begin op = tmpg_pkg::OP_CMP;    state_next = tmpg_pkg::ST_BRANCH; end
            tmpg_pkg::ST_BRANCH:
            begin
                if (status.trap)
                begin
                    op         = tmpg_pkg::OP_DIV_VA;
                    state_next = tmpg_pkg::ST_WAIT_VA;
                end
                else
                begin
                    op         = tmpg_pkg::OP_DIV_MA;
                    state_next = tmpg_pkg::ST_WAIT_MA;
                end
            end
            tmpg_pkg::ST_WAIT_VA:
            begin
                if (status.div_done)
                begin
                    op         = tmpg_pkg::OP_DIV_MV;
                    state_next = tmpg_pkg::ST_WAIT_MV;
                end
            end
            tmpg_pkg::ST_WAIT_MV:
            begin
                if (status.div_done)
                begin
                    op         = tmpg_pkg::OP_TRAP_END;
                    state_next = tmpg_pkg::ST_EVAL;
                end
            end
            tmpg_pkg::ST_WAIT_MA:
            begin
                if (status.div_done)
                begin
                    op         = tmpg_pkg::OP_SQRT;
                    state_next = tmpg_pkg::ST_WAIT_SQ;
                end
            end
            tmpg_pkg::ST_WAIT_SQ:
            begin
                if (status.sqrt_done)
                begin
                    op         = tmpg_pkg::OP_TRI_TA;
                    state_next = tmpg_pkg::ST_TRI_MUL;
                end
            end
            tmpg_pkg::ST_TRI_MUL: begin op = tmpg_pkg::OP_MUL_A_TA; state_next = tmpg_pkg::ST_TRI_PK; end
            tmpg_pkg::ST_TRI_PK:  begin op = tmpg_pkg::OP_TRI_PK;   state_next = tmpg_pkg::ST_EVAL; end
            // Evaluate the profile at the current tick
            tmpg_pkg::ST_EVAL:
            begin
                op = tmpg_pkg::OP_EVAL;
                unique case (status.cls)
                    tmpg_pkg::CLS_FIN: state_next = tmpg_pkg::ST_OUT;
                    tmpg_pkg::CLS_ACC: state_next = tmpg_pkg::ST_A1;
                    tmpg_pkg::CLS_CRU: state_next = tmpg_pkg::ST_C1;
                    tmpg_pkg::CLS_DEC: state_next = tmpg_pkg::ST_D1;
                    default:           state_next = tmpg_pkg::ST_OUT;
                endcase
            end
            tmpg_pkg::ST_A1: begin op = tmpg_pkg::OP_MUL_AE;   state_next = tmpg_pkg::ST_A2; end
            tmpg_pkg::ST_A2: begin op = tmpg_pkg::OP_V_MIN;    state_next = tmpg_pkg::ST_A3; end
            tmpg_pkg::ST_A3: begin op = tmpg_pkg::OP_MUL_VE;   state_next = tmpg_pkg::ST_A4; end
            tmpg_pkg::ST_A4: begin op = tmpg_pkg::OP_ACC_HALF; state_next = tmpg_pkg::ST_OUT; end
            tmpg_pkg::ST_C1: begin op = tmpg_pkg::OP_MUL_A_TA; state_next = tmpg_pkg::ST_C2; end
            tmpg_pkg::ST_C2: begin op = tmpg_pkg::OP_V_MIN16;  state_next = tmpg_pkg::ST_C3; end
            tmpg_pkg::ST_C3: begin op = tmpg_pkg::OP_MUL_VTA;  state_next = tmpg_pkg::ST_C4; end
            tmpg_pkg::ST_C4: begin op = tmpg_pkg::OP_CR_S1;    state_next = tmpg_pkg::ST_C5; end
            tmpg_pkg::ST_C5: begin op = tmpg_pkg::OP_CR_ADD;   state_next = tmpg_pkg::ST_C6; end
            tmpg_pkg::ST_C6: begin op = tmpg_pkg::OP_CR_SUB;   state_next = tmpg_pkg::ST_OUT; end
            tmpg_pkg::ST_D1: begin op = tmpg_pkg::OP_MUL_AE;   state_next = tmpg_pkg::ST_D2; end
            tmpg_pkg::ST_D2: begin op = tmpg_pkg::OP_DE_ACE;   state_next = tmpg_pkg::ST_D3; end
            tmpg_pkg::ST_D3: begin op = tmpg_pkg::OP_DE_V;     state_next = tmpg_pkg::ST_D4; end
            tmpg_pkg::ST_D4: begin op = tmpg_pkg::OP_DE_VR;    state_next = tmpg_pkg::ST_D5; end
            tmpg_pkg::ST_D5: begin op = tmpg_pkg::OP_MUL_WR;   state_next = tmpg_pkg::ST_D6; end
            tmpg_pkg::ST_D6: begin op = tmpg_pkg::OP_DE_S;     state_next = tmpg_pkg::ST_OUT; end
            // Hand the result to the output register once it is free
            tmpg_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    op         = tmpg_pkg::OP_OUT;
                    state_next = tmpg_pkg::ST_IDLE;
                end
            end
            default: state_next = tmpg_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/trapezoidal_motion_profile_generator.sv
// A tick item is evaluated and, in accelerate, cruise or decelerate, runs its extra steps on
//   the one shared 32x32 multiplier before its result goes to the output register.
// A start item first runs the shared divider (one quotient bit per cycle, two 48-bit
//   divisions, or one division plus a 32-step root for a triangle).
// Throughput: one item at a time. The next transfer is taken the cycle after the result is
//   loaded into the output register. A result still stalled there holds off the next load.
// Reset: asynchronous, clears the move to idle and the registers to their defaults.
`default_nettype none

module trapezoidal_motion_profile_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire tmpg_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output tmpg_pkg::out_item_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [tmpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmpg_pkg::REG_W-1:0]      cfg_data
);

    tmpg_pkg::dp_op_t     op;
    tmpg_pkg::dp_status_t status;

    tmpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    tmpg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// File: tb/sv/tmpg_checker.sv
// Checker for the profile generator: predicts each result and compares transfers.
`timescale 1ns / 1ps

module tmpg_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  tmpg_pkg::in_item_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  tmpg_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [tmpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmpg_pkg::REG_W-1:0]          cfg_data,
    output int                                  pending,
    output int                                  errors,
    output int                                  moves_seen,
    output int                                  done_seen
);

    localparam longint unsigned U32M = 64'hFFFF_FFFF;

    // Shadow registers and move state
    logic [30:0]       vel_limit;
    logic [30:0]       accel;
    logic signed [31:0] origin;
    logic              heading_neg;
    logic [31:0]       span;
    logic [31:0]       ramp_time;
    logic [31:0]       move_time;
    logic [31:0]       top_speed;
    logic [31:0]       ticks;
    logic              moving;

    tmpg_pkg::out_item_t expected_q[$];

    function automatic longint unsigned clip_u32(longint unsigned x);
        return (x > U32M) ? U32M : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] place(longint unsigned s);
        longint p;
        if (s > U32M)
            s = U32M;
        p = heading_neg ? longint'(origin) - longint'(s) : longint'(origin) + longint'(s);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[31:0];
    endfunction

    // Work out one item's result and update the move state
    function automatic tmpg_pkg::out_item_t profile_step(tmpg_pkg::in_item_t it);
        tmpg_pkg::out_item_t r;
        longint unsigned a, vm, mag, ta, tt, pk, ce, t, v, s, vr, sub;
        longint d;
        a  = (accel == 0) ? 1 : accel;
        vm = (vel_limit == 0) ? 1 : vel_limit;
        if (it.command == tmpg_pkg::CMD_START)
        begin
            d = longint'(it.target_position) - longint'(it.encoder_position);
            origin = it.encoder_position;
            heading_neg = d < 0;
            mag = (d < 0) ? -d : d;
            span = mag[31:0];
            if (mag > (vm * vm) / a)
            begin
                ta = clip_u32((vm << tmpg_pkg::FRAC_BITS) / a);
                ramp_time = ta[31:0];
                tt = clip_u32(ta + clip_u32((mag << tmpg_pkg::FRAC_BITS) / vm));
                move_time = tt[31:0];
                top_speed = vm[31:0];
            end
            else
            begin
                ta = clip_u32(int_sqrt(((mag << tmpg_pkg::FRAC_BITS) / a)
                                       << tmpg_pkg::FRAC_BITS));
                ramp_time = ta[31:0];
                tt = clip_u32(2 * ta);
                move_time = tt[31:0];
                pk = (a * ta) >> tmpg_pkg::FRAC_BITS;
                if (pk > 64'h7FFF_FFFF)
                    pk = 64'h7FFF_FFFF;
                top_speed = pk[31:0];
            end
            ticks = 0;
            moving = 1'b1;
        end
        else if (moving && ticks != 32'hFFFF_FFFF)
            ticks = ticks + 32'd1;

        t  = longint'(ticks) << tmpg_pkg::FRAC_BITS;
        ta = ramp_time;
        tt = move_time;
        pk = top_speed;
        mag = span;
        ce = (tt >= ta) ? tt - ta : 0;
        r.done_res = 1'b0;
        if (!moving || t >= tt)
        begin
            r.done_res = moving;
            moving = 1'b0;
            r.velocity_command = '0;
            r.position_setpoint = place(mag);
            r.phase = tmpg_pkg::PH_IDLE;
            return r;
        end
        if (t <= ta)
        begin
            r.phase = tmpg_pkg::PH_ACCEL;
            v = (a * t) >> tmpg_pkg::FRAC_BITS;
            if (v > pk)
                v = pk;
            s = (v * t) >> (tmpg_pkg::FRAC_BITS + 1);
        end
        else if (t <= ce)
        begin
            r.phase = tmpg_pkg::PH_CRUISE;
            v = (a * ta) >> tmpg_pkg::FRAC_BITS;
            if (v > pk)
                v = pk;
            s = ((v * ta) >> (tmpg_pkg::FRAC_BITS + 1))
              + ((pk * (t - ta)) >> tmpg_pkg::FRAC_BITS);
            v = pk;
        end
        else
        begin
            r.phase = tmpg_pkg::PH_DECEL;
            v = (a * (t - ce)) >> tmpg_pkg::FRAC_BITS;
            v = (v >= pk) ? 0 : pk - v;
            vr = (a * (tt - t)) >> tmpg_pkg::FRAC_BITS;
            if (vr > pk)
                vr = pk;
            sub = (vr * (tt - t)) >> (tmpg_pkg::FRAC_BITS + 1);
            s = (sub >= mag) ? 0 : mag - sub;
        end
        r.velocity_command = heading_neg ? (32'd0 - v[31:0]) : v[31:0];
        r.position_setpoint = place(s);
        return r;
    endfunction

    // Watch the channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        tmpg_pkg::out_item_t want;
        if (!rst_n)
        begin
            vel_limit = tmpg_pkg::MAX_VEL_RESET;
            accel = tmpg_pkg::ACCEL_RESET;
            origin = '0;
            heading_neg = 1'b0;
            span = '0;
            ramp_time = '0;
            move_time = '0;
            top_speed = '0;
            ticks = '0;
            moving = 1'b0;
            expected_q.delete();
            pending = 0;
            errors = 0;
            moves_seen = 0;
            done_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tmpg_pkg::CFG_MAX_VEL)
                    vel_limit = cfg_data;
                else
                    accel = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.command == tmpg_pkg::CMD_START)
                    moves_seen++;
                expected_q.push_back(profile_step(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: %p", out_data);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.done_res)
                        done_seen++;
                    if (want.velocity_command != out_data.velocity_command
                        || want.position_setpoint != out_data.position_setpoint
                        || want.phase != out_data.phase
                        || want.done_res != out_data.done_res)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected vel %0d pos %0d ph %0d done %0b,",
                                      " got vel %0d pos %0d ph %0d done %0b"},
                                     want.velocity_command, want.position_setpoint,
                                     want.phase, want.done_res,
                                     out_data.velocity_command, out_data.position_setpoint,
                                     out_data.phase, out_data.done_res);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Top of the profile generator testbench: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_top;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    tmpg_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    tmpg_pkg::out_item_t out_data;
    logic cfg_we;
    logic [tmpg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tmpg_pkg::REG_W-1:0] cfg_data;
    int pending;
    int errors;
    int moves_seen;
    int done_seen;
    int items_sent;
    bit gaps_on;
    bit stalls_on;
    int stall_left;

    trapezoidal_motion_profile_generator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tmpg_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors),
        .moves_seen(moves_seen), .done_seen(done_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stall after each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            w = stalls_on ? $urandom_range(0, 17) : 0;
            stall_left <= w;
            out_stall <= (w != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    // One input transfer, with a random gap ahead of it
    task automatic send_item(logic cmd, logic [31:0] tgt, logic [31:0] enc);
        int gap;
        bit free;
        tmpg_pkg::in_item_t it;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.command = cmd;
        it.target_position = tgt;
        it.encoder_position = enc;
        in_valid <= 1'b1;
        in_data <= it;
        forever
        begin
            @(negedge clk);
            free = !in_stall;
            @(posedge clk);
            if (free)
                break;
        end
        items_sent++;
    endtask

    task automatic tick_run(int n);
        repeat (n) send_item(tmpg_pkg::CMD_TICK, $urandom, $urandom);
    endtask

    // Let the block go idle, then write one register
    task automatic write_reg(logic [tmpg_pkg::CFG_IDX_W-1:0] idx,
                             logic [tmpg_pkg::REG_W-1:0] val);
        @(posedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random move: mostly short distances, some full-range, then ticks
    task automatic random_phase(int n);
        logic [31:0] enc;
        logic [31:0] travel;
        int k;
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 9);
            enc = $urandom;
            if (k < 6)
                travel = $urandom_range(0, 32'h0040_0000);
            else if (k < 8)
                travel = $urandom_range(0, 32'h0000_4000);
            else
                travel = $urandom;
            if ($urandom_range(0, 1))
                travel = -travel;
            if (k == 9)
                send_item(tmpg_pkg::CMD_START, $urandom, enc);
            else
                send_item(tmpg_pkg::CMD_START, enc + travel, enc);
            tick_run($urandom_range(0, 40));
        end
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = tmpg_pkg::CFG_MAX_VEL;
        cfg_data = '0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, zero distance, both directions, extremes
        send_item(tmpg_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(tmpg_pkg::CMD_START, 32'h1234_0000, 32'h1234_0000);
        send_item(tmpg_pkg::CMD_TICK, 32'h0, 32'h0);
        send_item(tmpg_pkg::CMD_START, 32'h0020_0000, 32'h0);
        tick_run(8);
        send_item(tmpg_pkg::CMD_START, 32'h8000_0000, 32'h7FFF_FFFF);
        tick_run(4);
        send_item(tmpg_pkg::CMD_START, 32'h7FFF_FFFF, 32'h8000_0000);
        tick_run(3);
        send_item(tmpg_pkg::CMD_START, 32'hFFFF_0000, 32'h0001_0000);
        tick_run(5);

        random_phase(150);

        // Both limits at their maximum
        write_reg(tmpg_pkg::CFG_MAX_VEL, 31'h7FFF_FFFF);
        write_reg(tmpg_pkg::CFG_ACCEL, 31'h7FFF_FFFF);
        random_phase(120);

        // Both at the minimum; zero behaves as one
        write_reg(tmpg_pkg::CFG_MAX_VEL, 31'd1);
        write_reg(tmpg_pkg::CFG_ACCEL, 31'd0);
        random_phase(100);

        // Slow cruise with hard acceleration, then the reverse
        write_reg(tmpg_pkg::CFG_MAX_VEL, 31'd0);
        write_reg(tmpg_pkg::CFG_ACCEL, 31'h7FFF_FFFF);
        random_phase(80);
        write_reg(tmpg_pkg::CFG_MAX_VEL, 31'h7FFF_FFFF);
        write_reg(tmpg_pkg::CFG_ACCEL, 31'd1);
        random_phase(80);

        // Random settings, first with full-range bits, then within set ranges
        write_reg(tmpg_pkg::CFG_MAX_VEL, tmpg_pkg::REG_W'($urandom));
        write_reg(tmpg_pkg::CFG_ACCEL, tmpg_pkg::REG_W'($urandom));
        random_phase(80);
        write_reg(tmpg_pkg::CFG_MAX_VEL,
                  tmpg_pkg::REG_W'($urandom_range(32'h1_0000, 32'h80_0000)));
        write_reg(tmpg_pkg::CFG_ACCEL,
                  tmpg_pkg::REG_W'($urandom_range(32'h1000, 32'h4_0000)));
        random_phase(100);

        @(posedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("Sent %0d items over seven register settings: %0d moves started, %0d finished.",
                 items_sent, moves_seen, done_seen);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("tb_top failed");
        $finish;
    end

endmodule
